### design/erff_pkg.sv
package erff_pkg;

    // Field widths
    localparam int BYTE_W        = 8;
    localparam int MAC_W         = 48;
    localparam int LEN_W         = 14;
    localparam int TYPE_W        = 16;
    localparam int CNT_W         = 32;
    localparam int SLOT_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int PROTO_W       = 17;
    localparam int PROTO_ENTRIES = 4;

    // Number of handler slots that take part in the search
    localparam int HANDLER_SLOTS = 4;

    // Frame layout and limits
    localparam int HEADER_BYTES = 14;
    localparam logic [LEN_W-1:0] DEST_END   = LEN_W'(6);
    localparam logic [LEN_W-1:0] SRC_END    = LEN_W'(12);
    localparam logic [LEN_W-1:0] TYPE_END   = LEN_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX    = '1;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1514);
    localparam logic [TYPE_W-1:0] TYPE_MIN  = 16'h0600;
    localparam logic [MAC_W-1:0] MAC_BROADCAST = '1;
    localparam int MULTICAST_BIT = 40;
    localparam int PROTO_ACTIVE_BIT = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_3    = 3'd5;

    typedef enum logic [2:0] {
        VERDICT_MATCHED    = 3'd0,
        VERDICT_UNHANDLED  = 3'd1,
        VERDICT_FILTERED   = 3'd2,
        VERDICT_BAD_LENGTH = 3'd3,
        VERDICT_BAD_SOURCE = 3'd4,
        VERDICT_BAD_TYPE   = 3'd5
    } verdict_t;

    // Configuration register set
    typedef struct packed {
        logic [MAC_W-1:0]                            local_address;
        logic [LEN_W-1:0]                            len_limit;
        logic [PROTO_ENTRIES-1:0][PROTO_W-1:0]       proto_entry;
    } cfg_t;

    // Captured header of one complete frame
    typedef struct packed {
        logic [LEN_W-1:0]  rx_length;
        logic [TYPE_W-1:0] frame_type;
        logic [MAC_W-1:0]  source_address;
        logic [MAC_W-1:0]  destination_address;
    } header_t;

    // Result item; the last member sits in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]  unhandled_total;
        logic [CNT_W-1:0]  invalid_total;
        logic [CNT_W-1:0]  filtered_total;
        logic [CNT_W-1:0]  broadcast_total;
        logic [CNT_W-1:0]  accepted_total;
        logic [LEN_W-1:0]  rx_length;
        logic [MAC_W-1:0]  destination_address;
        logic [MAC_W-1:0]  source_address;
        logic [TYPE_W-1:0] frame_type;
        logic [SLOT_W-1:0] handler_slot;
        logic              broadcast_hit;
        verdict_t          verdict;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

### design/ethernet_rx_frame_filter_core.sv
// Receive frame filter. Frame bytes enter one item per clock on the slave stream, with
// tlast on the final byte; every byte is taken back to back as long as results drain.
// The destination, source and EtherType are captured from the first 14 bytes, and at the
// last byte one result item leaves on the master stream carrying the verdict, the captured
// header, the saturated frame length and the five wrapping counters. The path is an input
// register, a header register and a result register, passed in that order once the
// last byte is accepted. Only a last byte can stall: input tready drops when the
// header and result registers are both full and the master side holds tready low. The
// configuration port takes a write in every cycle and is meant to be written while no
// frame is in flight.
module ethernet_rx_frame_filter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [erff_pkg::BYTE_W-1:0]     s_axis_tdata,   // frame_byte
    input  logic                            s_axis_tlast,   // last_byte
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // verdict, broadcast_hit, handler_slot, frame_type, source_address,
    // destination_address, frame length, accepted_total, broadcast_total,
    // filtered_total, invalid_total, unhandled_total, zero fill
    output logic [erff_pkg::TDATA_W-1:0]    m_axis_tdata,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [erff_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erff_pkg::MAC_W-1:0]      cfg_data
);
    import erff_pkg::*;

    cfg_t    cfg;
    header_t hdr;
    logic    hdr_valid;
    logic    hdr_ready;
    result_t result;

    // Configuration registers
    erff_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Byte capture into header fields
    erff_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr)
    );

    // Frame checks, handler match and counters
    erff_verdict u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .cfg       (cfg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = TDATA_W'(result);

    // A handler slot is reported only for a matched frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (result.verdict != VERDICT_MATCHED) |-> result.handler_slot == '0)
        else $error("handler slot set on a frame without a matched handler");

    // A length inside the configured window must not yield a length verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (result.rx_length >= LEN_W'(HEADER_BYTES))
        && (result.rx_length <= cfg.len_limit)
        |-> result.verdict != VERDICT_BAD_LENGTH)
        else $error("frame length in range but verdict is bad length");

    // Frames past the destination filter are broadcast or addressed to this station.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((result.verdict == VERDICT_MATCHED)
        || (result.verdict == VERDICT_UNHANDLED)
        || (result.verdict == VERDICT_BAD_SOURCE)
        || (result.verdict == VERDICT_BAD_TYPE))
        |-> result.broadcast_hit || (result.destination_address == cfg.local_address))
        else $error("frame passed the destination filter with a foreign address");

    // The broadcast flag follows the captured destination.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> result.broadcast_hit == (result.destination_address == MAC_BROADCAST))
        else $error("broadcast flag disagrees with destination address");

endmodule

### design/erff_cfg_regs.sv
module erff_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [erff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erff_pkg::MAC_W-1:0]     cfg_data,
    output erff_pkg::cfg_t                 cfg
);
    import erff_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR: cfg_next.local_address    = cfg_data;
                CFG_MAX_LEN:    cfg_next.len_limit        = cfg_data[LEN_W-1:0];
                CFG_PROTO_0:    cfg_next.proto_entry[0]   = cfg_data[PROTO_W-1:0];
                CFG_PROTO_1:    cfg_next.proto_entry[1]   = cfg_data[PROTO_W-1:0];
                CFG_PROTO_2:    cfg_next.proto_entry[2]   = cfg_data[PROTO_W-1:0];
                CFG_PROTO_3:    cfg_next.proto_entry[3]   = cfg_data[PROTO_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= '0;
            cfg_reg.len_limit <= MAX_LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/erff_capture.sv
module erff_capture (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [erff_pkg::BYTE_W-1:0] in_byte,
    input  logic                        in_last,
    output logic                        hdr_valid,
    input  logic                        hdr_ready,
    output erff_pkg::header_t           hdr
);
    import erff_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [MAC_W-1:0]  dest_reg, dest_next;
    logic [MAC_W-1:0]  src_reg, src_next;
    logic [TYPE_W-1:0] type_reg, type_next;

    logic              hdr_valid_reg, hdr_valid_next;
    header_t           hdr_reg;

    logic              hdr_free;
    logic              proc;
    logic [LEN_W-1:0]  len_upd;
    logic [MAC_W-1:0]  dest_upd;
    logic [MAC_W-1:0]  src_upd;
    logic [TYPE_W-1:0] type_upd;

    // A registered item is consumed unless it ends a frame and the header slot is full.
    assign hdr_free  = !hdr_valid_reg || hdr_ready;
    assign proc      = in_valid_reg && (!in_last_reg || hdr_free);
    assign in_ready  = !in_valid_reg || proc;
    assign hdr_valid = hdr_valid_reg;
    assign hdr       = hdr_reg;

    // Shift the byte into the header field that its position belongs to.
    always_comb
    begin
        dest_upd = dest_reg;
        src_upd  = src_reg;
        type_upd = type_reg;
        if (pos_reg < DEST_END)
        begin
            dest_upd = {dest_reg[MAC_W-BYTE_W-1:0], in_byte_reg};
        end
        else if (pos_reg < SRC_END)
        begin
            src_upd = {src_reg[MAC_W-BYTE_W-1:0], in_byte_reg};
        end
        else if (pos_reg < TYPE_END)
        begin
            type_upd = {type_reg[TYPE_W-BYTE_W-1:0], in_byte_reg};
        end
        len_upd = (pos_reg == LEN_MAX) ? LEN_MAX : pos_reg + LEN_W'(1);
    end

    // Frame state advances on every consumed item and clears at the end of a frame.
    always_comb
    begin
        pos_next  = pos_reg;
        dest_next = dest_reg;
        src_next  = src_reg;
        type_next = type_reg;
        if (proc)
        begin
            if (in_last_reg)
            begin
                pos_next  = '0;
                dest_next = '0;
                src_next  = '0;
                type_next = '0;
            end
            else
            begin
                pos_next  = len_upd;
                dest_next = dest_upd;
                src_next  = src_upd;
                type_next = type_upd;
            end
        end
    end

    // Handshake state of the input and header registers
    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
        if (proc && in_last_reg)
        begin
            hdr_valid_next = 1'b1;
        end
        else if (hdr_ready)
        begin
            hdr_valid_next = 1'b0;
        end
        else
        begin
            hdr_valid_next = hdr_valid_reg;
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            hdr_valid_reg <= 1'b0;
            pos_reg       <= '0;
            dest_reg      <= '0;
            src_reg       <= '0;
            type_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            hdr_valid_reg <= hdr_valid_next;
            pos_reg       <= pos_next;
            dest_reg      <= dest_next;
            src_reg       <= src_next;
            type_reg      <= type_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (proc && in_last_reg)
        begin
            hdr_reg.rx_length           <= len_upd;
            hdr_reg.frame_type          <= type_upd;
            hdr_reg.source_address      <= src_upd;
            hdr_reg.destination_address <= dest_upd;
        end
    end

endmodule

### design/erff_verdict.sv
module erff_verdict (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hdr_valid,
    output logic              hdr_ready,
    input  erff_pkg::header_t hdr,
    input  erff_pkg::cfg_t    cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output erff_pkg::result_t result
);
    import erff_pkg::*;

    logic             out_valid_reg, out_valid_next;
    result_t          result_reg, result_next;

    logic [CNT_W-1:0] accepted_reg, accepted_next;
    logic [CNT_W-1:0] bcast_cnt_reg, bcast_cnt_next;
    logic [CNT_W-1:0] filtered_reg, filtered_next;
    logic [CNT_W-1:0] invalid_reg, invalid_next;
    logic [CNT_W-1:0] unhandled_reg, unhandled_next;

    logic             take;
    logic             bcast;
    logic             len_bad;
    logic             dest_miss;
    logic             src_bad;
    logic             type_bad;
    logic             found;
    logic [SLOT_W-1:0] match_slot;
    verdict_t         verdict;

    assign hdr_ready = !out_valid_reg || out_ready;
    assign take      = hdr_valid && hdr_ready;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Frame checks
    assign bcast     = hdr.destination_address == MAC_BROADCAST;
    assign len_bad   = (hdr.rx_length < LEN_W'(HEADER_BYTES))
                       || (hdr.rx_length > cfg.len_limit);
    assign dest_miss = !bcast && (hdr.destination_address != cfg.local_address);
    assign src_bad   = (hdr.source_address == '0) || hdr.source_address[MULTICAST_BIT];
    assign type_bad  = hdr.frame_type < TYPE_MIN;

    // Lowest active handler slot whose EtherType matches
    always_comb
    begin
        found      = 1'b0;
        match_slot = '0;
        for (int k = HANDLER_SLOTS - 1; k >= 0; k--)
        begin
            if (cfg.proto_entry[k][PROTO_ACTIVE_BIT]
                && (cfg.proto_entry[k][TYPE_W-1:0] == hdr.frame_type))
            begin
                found      = 1'b1;
                match_slot = SLOT_W'(k);
            end
        end
    end

    // Verdict and counter updates, checks taken in priority order
    always_comb
    begin
        accepted_next  = accepted_reg;
        bcast_cnt_next = bcast_cnt_reg;
        filtered_next  = filtered_reg;
        invalid_next   = invalid_reg;
        unhandled_next = unhandled_reg;
        if (len_bad)
        begin
            verdict      = VERDICT_BAD_LENGTH;
            invalid_next = invalid_reg + CNT_W'(1);
        end
        else if (dest_miss)
        begin
            verdict       = VERDICT_FILTERED;
            filtered_next = filtered_reg + CNT_W'(1);
        end
        else if (src_bad)
        begin
            verdict      = VERDICT_BAD_SOURCE;
            invalid_next = invalid_reg + CNT_W'(1);
        end
        else if (type_bad)
        begin
            verdict      = VERDICT_BAD_TYPE;
            invalid_next = invalid_reg + CNT_W'(1);
        end
        else
        begin
            accepted_next = accepted_reg + CNT_W'(1);
            if (bcast)
            begin
                bcast_cnt_next = bcast_cnt_reg + CNT_W'(1);
            end
            if (found)
            begin
                verdict = VERDICT_MATCHED;
            end
            else
            begin
                verdict        = VERDICT_UNHANDLED;
                unhandled_next = unhandled_reg + CNT_W'(1);
            end
        end
    end

    // Result item assembly
    always_comb
    begin
        result_next.verdict             = verdict;
        result_next.broadcast_hit       = bcast;
        result_next.handler_slot        = (verdict == VERDICT_MATCHED) ? match_slot : '0;
        result_next.frame_type          = hdr.frame_type;
        result_next.source_address      = hdr.source_address;
        result_next.destination_address = hdr.destination_address;
        result_next.rx_length           = hdr.rx_length;
        result_next.accepted_total      = accepted_next;
        result_next.broadcast_total     = bcast_cnt_next;
        result_next.filtered_total      = filtered_next;
        result_next.invalid_total       = invalid_next;
        result_next.unhandled_total     = unhandled_next;
    end

    // Output handshake
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accepted_reg  <= '0;
            bcast_cnt_reg <= '0;
            filtered_reg  <= '0;
            invalid_reg   <= '0;
            unhandled_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                accepted_reg  <= accepted_next;
                bcast_cnt_reg <= bcast_cnt_next;
                filtered_reg  <= filtered_next;
                invalid_reg   <= invalid_next;
                unhandled_reg <= unhandled_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### test/frame_verdict_checker.sv
module frame_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [erff_pkg::BYTE_W-1:0]     s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [erff_pkg::TDATA_W-1:0]    m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [erff_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erff_pkg::MAC_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import erff_pkg::*;

    // Mirror of the filter registers.
    logic [MAC_W-1:0]   local_mac;
    logic [LEN_W-1:0]   length_limit;
    logic [PROTO_W-1:0] handler_table [PROTO_ENTRIES];

    // Per-frame capture and the running totals.
    logic [LEN_W-1:0]   byte_count;
    logic [MAC_W-1:0]   dest_mac;
    logic [MAC_W-1:0]   src_mac;
    logic [TYPE_W-1:0]  ether_type;
    logic [CNT_W-1:0]   n_accepted;
    logic [CNT_W-1:0]   n_broadcast;
    logic [CNT_W-1:0]   n_filtered;
    logic [CNT_W-1:0]   n_invalid;
    logic [CNT_W-1:0]   n_unhandled;

    // Verdicts predicted but not yet seen on the result stream.
    result_t            pending_verdicts [$];
    int                 verdict_no;
    int                 print_budget;

    // Count a fault; the log is capped so that a badly broken block stays readable.
    task automatic report_fault(input string msg);
        mismatches++;
        if (print_budget > 0)
        begin
            print_budget--;
            $display("checker: result %0d: %s", verdict_no, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic track_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [MAC_W-1:0] data);
        case (idx)
            CFG_LOCAL_ADDR: local_mac = data;
            CFG_MAX_LEN:    length_limit = data[LEN_W-1:0];
            CFG_PROTO_0,
            CFG_PROTO_1,
            CFG_PROTO_2,
            CFG_PROTO_3:    handler_table[int'(idx - CFG_PROTO_0)] = data[PROTO_W-1:0];
            default:        ;
        endcase
    endtask

    // Take one frame byte; on the last byte work out the verdict and the totals.
    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [LEN_W-1:0] len;
        logic             bcast;
        logic             found;
        result_t          r;
        if (byte_count < DEST_END)
            dest_mac = {dest_mac[MAC_W-BYTE_W-1:0], b};
        else if (byte_count < SRC_END)
            src_mac = {src_mac[MAC_W-BYTE_W-1:0], b};
        else if (byte_count < TYPE_END)
            ether_type = {ether_type[TYPE_W-BYTE_W-1:0], b};
        len = (byte_count < LEN_MAX) ? byte_count + 1'b1 : LEN_MAX;
        byte_count = len;
        if (last)
        begin
            bcast = (dest_mac == MAC_BROADCAST);
            r = '0;
            if (len < LEN_W'(HEADER_BYTES) || len > length_limit)
            begin
                r.verdict = VERDICT_BAD_LENGTH;
                n_invalid++;
            end
            else if (!bcast && dest_mac != local_mac)
            begin
                r.verdict = VERDICT_FILTERED;
                n_filtered++;
            end
            else if (src_mac == '0 || src_mac[MULTICAST_BIT])
            begin
                r.verdict = VERDICT_BAD_SOURCE;
                n_invalid++;
            end
            else if (ether_type < TYPE_MIN)
            begin
                r.verdict = VERDICT_BAD_TYPE;
                n_invalid++;
            end
            else
            begin
                n_accepted++;
                if (bcast)
                    n_broadcast++;
                // The lowest active slot with the same EtherType wins.
                found = 1'b0;
                for (int k = 0; k < HANDLER_SLOTS; k++)
                begin
                    if (!found && handler_table[k][PROTO_ACTIVE_BIT]
                        && handler_table[k][TYPE_W-1:0] == ether_type)
                    begin
                        found = 1'b1;
                        r.handler_slot = SLOT_W'(k);
                    end
                end
                if (found)
                    r.verdict = VERDICT_MATCHED;
                else
                begin
                    r.verdict = VERDICT_UNHANDLED;
                    n_unhandled++;
                end
            end
            r.broadcast_hit       = bcast;
            r.frame_type          = ether_type;
            r.source_address      = src_mac;
            r.destination_address = dest_mac;
            r.rx_length           = len;
            r.accepted_total      = n_accepted;
            r.broadcast_total     = n_broadcast;
            r.filtered_total      = n_filtered;
            r.invalid_total       = n_invalid;
            r.unhandled_total     = n_unhandled;
            pending_verdicts.push_back(r);
            byte_count = '0;
            dest_mac   = '0;
            src_mac    = '0;
            ether_type = '0;
        end
    endtask

    task automatic check_verdict(input result_t got);
        result_t want;
        verdict_no++;
        if (pending_verdicts.size() == 0)
            report_fault("result item arrived with no verdict pending");
        else
        begin
            want = pending_verdicts.pop_front();
            compare_field("verdict", got.verdict, want.verdict);
            compare_field("broadcast_hit", got.broadcast_hit, want.broadcast_hit);
            compare_field("handler_slot", got.handler_slot, want.handler_slot);
            compare_field("frame_type", got.frame_type, want.frame_type);
            compare_field("source_address", got.source_address, want.source_address);
            compare_field("destination_address", got.destination_address,
                          want.destination_address);
            compare_field("rx_length", got.rx_length, want.rx_length);
            compare_field("accepted_total", got.accepted_total, want.accepted_total);
            compare_field("broadcast_total", got.broadcast_total, want.broadcast_total);
            compare_field("filtered_total", got.filtered_total, want.filtered_total);
            compare_field("invalid_total", got.invalid_total, want.invalid_total);
            compare_field("unhandled_total", got.unhandled_total, want.unhandled_total);
        end
    endtask

    // All three channels are sampled at the rising edge, before any update of that edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac    = '0;
            length_limit = MAX_LEN_RESET;
            for (int k = 0; k < PROTO_ENTRIES; k++)
                handler_table[k] = '0;
            byte_count   = '0;
            dest_mac     = '0;
            src_mac      = '0;
            ether_type   = '0;
            n_accepted   = '0;
            n_broadcast  = '0;
            n_filtered   = '0;
            n_invalid    = '0;
            n_unhandled  = '0;
            pending_verdicts.delete();
            verdict_no   = 0;
            print_budget = 100;
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_verdict(result_t'(m_axis_tdata[RESULT_W-1:0]));
            if (cfg_valid && cfg_ready)
                track_config(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tlast);
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

### test/tb_top.sv
module tb_top;
    import erff_pkg::*;

    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 400;

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [MAC_W-1:0] LOCAL_A   = 48'h02_11_22_33_44_55;
    localparam logic [MAC_W-1:0] SRC_OK    = 48'h00_1b_21_3c_4d_5e;
    localparam logic [MAC_W-1:0] SRC_MCAST = 48'h01_00_5e_00_00_01;
    localparam logic [MAC_W-1:0] SRC_TOP   = 48'hfe_ff_ff_ff_ff_ff;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [MAC_W-1:0]      cfg_data      = '0;
    int                    mismatches;
    int                    outstanding;

    // Settings currently programmed, used to aim the random frames.
    logic [MAC_W-1:0]                       cur_local;
    logic [PROTO_ENTRIES-1:0][PROTO_W-1:0]  cur_handlers;

    int  burst_left  = 0;
    int  bytes_sent  = 0;
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  ready_mode  = 0;
    int  mode_left   = 0;
    int  quiet       = 0;
    int  target;
    logic [PROTO_ENTRIES-1:0][PROTO_W-1:0]  mix;

    ethernet_rx_frame_filter_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_verdict_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    // Offer one byte; the sender runs in bursts with random gaps between them.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= BYTE_W'($urandom());
                s_axis_tlast  <= 1'($urandom());
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stop offering and wait until every verdict has come out and the pipe is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Program every register; unused upper data bits carry noise.
    task automatic program_filter(input logic [MAC_W-1:0] addr, input logic [LEN_W-1:0] limit,
                                  input logic [PROTO_ENTRIES-1:0][PROTO_W-1:0] handlers);
        write_reg(CFG_SPARE_A, random_mac());
        write_reg(CFG_LOCAL_ADDR, addr);
        write_reg(CFG_MAX_LEN, {(MAC_W-LEN_W)'({$urandom(), $urandom()}), limit});
        for (int k = 0; k < PROTO_ENTRIES; k++)
            write_reg(CFG_IDX_W'(CFG_PROTO_0 + k),
                      {(MAC_W-PROTO_W)'({$urandom(), $urandom()}), handlers[k]});
        write_reg(CFG_SPARE_B, random_mac());
        cfg_valid <= 1'b0;
        cur_local    = addr;
        cur_handlers = handlers;
    endtask

    task automatic drive_frame(input int len, input logic [MAC_W-1:0] dest,
                               input logic [MAC_W-1:0] src, input logic [TYPE_W-1:0] etype);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i < 6)
                b = BYTE_W'(dest >> (8 * (5 - i)));
            else if (i < 12)
                b = BYTE_W'(src >> (8 * (11 - i)));
            else if (i == 12)
                b = etype[15:8];
            else if (i == 13)
                b = etype[7:0];
            else
                b = BYTE_W'($urandom());
            push_byte(b, i == len - 1);
        end
    endtask

    // Mostly well-formed frames aimed at the programmed settings, the rest broken.
    task automatic random_frame();
        int                len;
        int                pick;
        logic [MAC_W-1:0]  dest;
        logic [MAC_W-1:0]  src;
        logic [TYPE_W-1:0] etype;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = $urandom_range(1, 13);
        else if (pick < 92)
            len = $urandom_range(14, 48);
        else
            len = $urandom_range(49, 120);

        pick = $urandom_range(0, 99);
        if (pick < 40)
            dest = cur_local;
        else if (pick < 65)
            dest = MAC_BROADCAST;
        else if (pick < 80)
            dest = cur_local ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
        else
            dest = random_mac();

        pick = $urandom_range(0, 99);
        src = random_mac();
        if (pick < 75)
        begin
            src[MULTICAST_BIT] = 1'b0;
            if (src == '0)
                src[0] = 1'b1;
        end
        else if (pick < 85)
            src = '0;
        else if (pick < 95)
            src[MULTICAST_BIT] = 1'b1;

        pick = $urandom_range(0, 99);
        if (pick < 50)
            etype = cur_handlers[$urandom_range(0, PROTO_ENTRIES - 1)][TYPE_W-1:0];
        else if (pick < 70)
            etype = TYPE_W'($urandom_range(32'h0600, 32'hffff));
        else if (pick < 85)
            etype = TYPE_W'($urandom_range(0, 32'h05ff));
        else
        begin
            case ($urandom_range(0, 3))
                0:       etype = TYPE_MIN;
                1:       etype = TYPE_MIN - 1'b1;
                2:       etype = '1;
                default: etype = '0;
            endcase
        end
        drive_frame(len, dest, src, etype);
    endtask

    // A random handler table, with repeated EtherTypes now and then.
    task automatic random_handlers(output logic [PROTO_ENTRIES-1:0][PROTO_W-1:0] handlers);
        for (int k = 0; k < PROTO_ENTRIES; k++)
        begin
            handlers[k][TYPE_W-1:0] = ($urandom_range(0, 1) == 0)
                ? TYPE_W'($urandom_range(32'h0600, 32'hffff)) : TYPE_W'($urandom());
            if (k > 0 && $urandom_range(0, 4) == 0)
                handlers[k][TYPE_W-1:0] = handlers[k-1][TYPE_W-1:0];
            handlers[k][PROTO_ACTIVE_BIT] = ($urandom_range(0, 3) != 0);
        end
    endtask

    // Result side: changing ready patterns, and a long hold-off when asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 150);
                end
                mode_left--;
                case (ready_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom());
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: give up after a long stretch with no item moving on any channel.
    initial
    begin
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        cur_local    = '0;
        cur_handlers = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight after reset: local address zero, no handlers.
        drive_frame(20, '0, SRC_OK, 16'h0800);
        drive_frame(20, MAC_BROADCAST, SRC_OK, 16'h0800);
        settle();

        // One table that exercises every verdict and slot.
        program_filter(LOCAL_A, MAX_LEN_RESET,
                       {{1'b1, 16'h88cc}, {1'b0, 16'h0806}, {1'b1, 16'h86dd}, {1'b1, 16'h0800}});
        drive_frame(60, LOCAL_A, SRC_OK, 16'h0800);
        drive_frame(64, LOCAL_A, SRC_OK, 16'h86dd);
        drive_frame(20, MAC_BROADCAST, SRC_OK, 16'h88cc);
        drive_frame(20, LOCAL_A, SRC_OK, 16'h0806);
        drive_frame(20, LOCAL_A ^ 48'h1, SRC_OK, 16'h0800);
        drive_frame(20, LOCAL_A, '0, 16'h0800);
        drive_frame(20, LOCAL_A, SRC_MCAST, 16'h0800);
        drive_frame(20, LOCAL_A, SRC_TOP, TYPE_MIN - 1'b1);
        drive_frame(14, LOCAL_A, SRC_TOP, TYPE_MIN);
        drive_frame(20, LOCAL_A, SRC_OK, 16'hffff);
        // Short frames leave unreached header fields at zero.
        drive_frame(1, LOCAL_A, SRC_OK, 16'h0800);
        drive_frame(6, MAC_BROADCAST, SRC_OK, 16'h0800);
        drive_frame(13, LOCAL_A, SRC_OK, 16'h0800);
        settle();

        // Broadcast as the local address, the smallest legal maximum, duplicate slots.
        program_filter(MAC_BROADCAST, LEN_W'(HEADER_BYTES),
                       {{1'b1, 16'h0600}, {1'b1, 16'hffff}, {1'b1, 16'h0800}, {1'b1, 16'h0800}});
        drive_frame(14, MAC_BROADCAST, SRC_OK, 16'h0800);
        drive_frame(15, MAC_BROADCAST, SRC_OK, 16'h0800);
        drive_frame(14, MAC_BROADCAST, SRC_OK, 16'hffff);
        drive_frame(14, LOCAL_A, SRC_OK, 16'h0800);
        drive_frame(14, MAC_BROADCAST, SRC_OK, TYPE_MIN);
        settle();

        // A maximum below the header length rejects everything.
        program_filter(LOCAL_A, LEN_W'(13), cur_handlers);
        drive_frame(14, MAC_BROADCAST, SRC_OK, 16'h0800);
        settle();
        program_filter(LOCAL_A, '0, cur_handlers);
        drive_frame(20, LOCAL_A, SRC_OK, 16'h0800);
        settle();

        // Largest maximum with every handler slot inactive.
        program_filter('0, LEN_MAX,
                       {{1'b0, 16'hffff}, {1'b0, 16'hffff}, {1'b0, 16'hffff}, {1'b0, 16'hffff}});
        drive_frame(30, '0, SRC_OK, 16'hffff);
        settle();

        // Hold the result side off while short frames keep coming, so the input stalls.
        hold_req = 1'b1;
        repeat (4)
            drive_frame(14, MAC_BROADCAST, SRC_OK, 16'h0800);
        settle();

        // Random phases under different settings; the first and last squeeze the output.
        random_handlers(mix);
        program_filter(random_mac(), LEN_W'($urandom_range(30, 80)), mix);
        hold_req = 1'b1;
        target = bytes_sent + 20;
        while (bytes_sent < target)
            random_frame();
        settle();

        random_handlers(mix);
        program_filter(MAC_BROADCAST, LEN_MAX, mix);
        target = bytes_sent + 20;
        while (bytes_sent < target)
            random_frame();
        settle();

        random_handlers(mix);
        program_filter(random_mac(), LEN_W'(13), mix);
        target = bytes_sent + 10;
        while (bytes_sent < target)
            random_frame();
        settle();

        random_handlers(mix);
        program_filter(random_mac(), LEN_W'(40), mix);
        hold_req = 1'b1;
        target = bytes_sent + 20;
        while (bytes_sent < target)
            random_frame();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
